FILE: hdl/assert_macros.svh
// Assertion macros for the postfix evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PFX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFX_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PFX_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFX_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: hdl/pfx_pkg.sv
package pfx_pkg;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned PtrW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChSlash = 8'h2f;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StUnderflow = 2'd1,
    StDivZero   = 2'd2,
    StOverflow  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmRead,
    FsmExec,
    FsmMul,
    FsmDiv,
    FsmWrite,
    FsmOut
  } fsm_e;
endpackage

FILE: hdl/pfx_stack_ram.sv
module pfx_stack_ram import pfx_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [PtrW-1:0] waddr_i,
  input  logic [31:0]     wdata_i,
  input  logic [PtrW-1:0] raddr_a_i,
  input  logic [PtrW-1:0] raddr_b_i,
  output logic [31:0]     rdata_a_o,
  output logic [31:0]     rdata_b_o
);
  logic [31:0] mem [StackDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end
endmodule

FILE: hdl/pfx_divider.sv
module pfx_divider import pfx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic [31:0] quo_q, quo_d, dvs_q, dvs_d;
  logic [31:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    quo_d = quo_q; dvs_d = dvs_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q;
    shifted = {rem_q, quo_q[31]};
    trial = shifted - {1'b0, dvs_q};
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 6'd0;
      rem_d = '0;
      neg_d = dividend_i[31] ^ divisor_i[31];
      quo_d = dividend_i[31] ? 32'(-dividend_i) : dividend_i;
      dvs_d = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
    end else if (busy_q) begin
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q + 6'd1;
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = shifted[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = neg_q ? 32'(-quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end
endmodule

FILE: hdl/postfix_expression_evaluator.sv
// Busy states per word: Read, Exec, then Write (+ -), Mul and Write (*), Div and Write (/), Out (NUL).
// The next word is taken back in Idle; the divider sets the worst case unless the output stalls.
// The stack lives in a 64-entry RAM with registered reads; the next word is
// taken once the previous one has written back or its result word is stored.
// Reset (rst_ni, async, active low) clears the count, error code and control.
// Stack contents are undefined after reset; only written entries are read.
`include "assert_macros.svh"
module postfix_expression_evaluator import pfx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o
);
  fsm_e        state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  status_e     err_q, err_d;
  logic [7:0]  ch_q, ch_d;
  logic [31:0] res_q, res_d, prod_q, prod_d;
  logic        ov_q, ov_d;
  logic [31:0] oval_q, oval_d;
  logic [1:0]  ost_q, ost_d;

  logic            we;
  logic [PtrW-1:0] waddr, ra, rb;
  logic [31:0]     wdata, rda, rdb, quot;
  logic            div_start, div_done;
  logic            acc;

  assign acc = in_valid_i && !in_stall_o;
  assign ra = PtrW'(cnt_q - CntW'(1));
  assign rb = PtrW'(cnt_q - CntW'(2));

  pfx_stack_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(rda), .rdata_b_o(rdb)
  );

  pfx_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(rdb), .divisor_i(rda),
    .done_o(div_done), .quot_o(quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      FsmIdle: begin
        if (acc) begin
          state_d = FsmRead;
        end
      end
      FsmRead:  state_d = FsmExec;
      FsmExec: begin
        if (ch_q == ChNul) begin
          state_d = FsmOut;
        end else if (err_q != StOk) begin
          state_d = FsmIdle;
        end else if (ch_q inside {[ChZero:ChNine]}) begin
          state_d = FsmIdle;
        end else if (ch_q inside {ChPlus, ChMinus, ChStar, ChSlash}) begin
          if (cnt_q < CntW'(2)) begin
            state_d = FsmIdle;
          end else if (ch_q == ChStar) begin
            state_d = FsmMul;
          end else if (ch_q == ChSlash) begin
            state_d = (rda == '0) ? FsmIdle : FsmDiv;
          end else begin
            state_d = FsmWrite;
          end
        end else begin
          state_d = FsmIdle;
        end
      end
      FsmMul:   state_d = FsmWrite;
      FsmDiv: begin
        if (div_done) begin
          state_d = FsmWrite;
        end
      end
      FsmWrite: state_d = FsmIdle;
      FsmOut: begin
        if (!ov_q || !out_stall_i) begin
          state_d = FsmIdle;
        end
      end
      default:  state_d = FsmIdle;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; err_d = err_q; ch_d = ch_q; res_d = res_q;
    prod_d = prod_q; ov_d = ov_q; oval_d = oval_q; ost_d = ost_q;
    we = 1'b0; waddr = ra; wdata = res_q; div_start = 1'b0;
    in_stall_o = (state_q != FsmIdle);
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      FsmIdle: begin
        if (acc) begin
          ch_d = char_code_i;
        end
      end
      FsmExec: begin
        if (ch_q == ChNul) begin
          cnt_d = '0;
          err_d = StOk;
        end else if (err_q != StOk) begin
          cnt_d = cnt_q;
        end else if (ch_q inside {[ChZero:ChNine]}) begin
          if (cnt_q >= CntW'(StackDepth)) begin
            err_d = StOverflow;
          end else begin
            we = 1'b1;
            waddr = PtrW'(cnt_q);
            wdata = {28'd0, ch_q[3:0]};
            cnt_d = cnt_q + CntW'(1);
          end
        end else if (ch_q inside {ChPlus, ChMinus, ChStar, ChSlash}) begin
          if (cnt_q < CntW'(2)) begin
            err_d = StUnderflow;
          end else if (ch_q == ChPlus) begin
            res_d = rdb + rda;
          end else if (ch_q == ChMinus) begin
            res_d = rdb - rda;
          end else if (ch_q == ChStar) begin
            prod_d = rdb * rda;
          end else if (rda == '0) begin
            err_d = StDivZero;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      FsmMul: res_d = prod_q;
      FsmDiv: begin
        if (div_done) begin
          res_d = quot;
        end
      end
      FsmWrite: begin
        we = 1'b1;
        waddr = rb;
        wdata = res_q;
        cnt_d = cnt_q - CntW'(1);
      end
      default: ;
    endcase
    // NUL: stage the result word once the output register is free
    if (state_q == FsmOut && (!ov_q || !out_stall_i)) begin
      ov_d = 1'b1;
      ost_d = res_q[1:0];
      oval_d = prod_q;
    end
    if (state_q == FsmExec && ch_q == ChNul) begin
      if (err_q != StOk) begin
        res_d = {30'd0, err_q};
        prod_d = '0;
      end else if (cnt_q == '0) begin
        res_d = {30'd0, StUnderflow};
        prod_d = '0;
      end else begin
        res_d = {30'd0, StOk};
        prod_d = rda;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle;
      cnt_q   <= '0;
      err_q   <= StOk;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    oval_q <= oval_d;
    ost_q  <= ost_d;
  end

  assign out_valid_o = ov_q;
  assign value_o = oval_q;
  assign status_o = ost_q;

  `PFX_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(StackDepth), "stack count beyond depth")
  `PFX_ASSERT(a_err_value, clk_i, rst_ni, (ov_q && ost_q != StOk) |-> oval_q == '0, "error value")
  `PFX_ASSERT_NEVER(a_busy_stall, clk_i, rst_ni, (state_q != FsmIdle) && acc, "word taken while busy")
endmodule
